>>> hw/rtl/drr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the discovery request responder.
// Holds the channel payload types, the protocol constants and the response frame builder.
// No dependencies.

package drr_pkg;

    // One received datagram byte with its side information.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       extended_port;
        logic       final_byte;
    } drr_in_t;

    // One result item.
    typedef struct packed {
        logic [7:0] tx_byte;
        logic [2:0] outcome;
        logic       run_end;
    } drr_out_t;

    // Endpoint configuration as held in the register bank.
    typedef struct packed {
        logic [63:0] tls_addr_high;
        logic [63:0] tls_addr_low;
        logic [63:0] tcp_addr_high;
        logic [63:0] tcp_addr_low;
        logic [15:0] tls_port;
        logic [15:0] tcp_port;
        logic [1:0]  endpoints_present;
    } drr_cfg_t;

    // Decision handed from the request checker to the response streamer.
    typedef struct packed {
        logic       valid;
        logic [2:0] outcome;
        logic       ext;
        logic       use_tls;
    } drr_job_t;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_TLS_ADDR_HIGH = 3'd0;
    localparam logic [2:0] REG_TLS_ADDR_LOW  = 3'd1;
    localparam logic [2:0] REG_TCP_ADDR_HIGH = 3'd2;
    localparam logic [2:0] REG_TCP_ADDR_LOW  = 3'd3;
    localparam logic [2:0] REG_TLS_PORT      = 3'd4;
    localparam logic [2:0] REG_TCP_PORT      = 3'd5;
    localparam logic [2:0] REG_ENDPOINTS     = 3'd6;

    // Outcome codes.
    localparam logic [2:0] OUT_RESPONSE     = 3'd0;
    localparam logic [2:0] OUT_TOO_SHORT    = 3'd1;
    localparam logic [2:0] OUT_BAD_HEADER   = 3'd2;
    localparam logic [2:0] OUT_BAD_VERSION  = 3'd3;
    localparam logic [2:0] OUT_NO_ENDPOINT  = 3'd4;

    // Protocol constants.
    localparam logic [7:0]  VER_BYTE        = 8'h01;
    localparam logic [7:0]  INV_VER_BYTE    = 8'hFE;
    localparam logic [15:0] BASIC_REQ_TYPE  = 16'h9000;
    localparam logic [15:0] BASIC_RSP_TYPE  = 16'h9001;
    localparam logic [15:0] EXT_TYPE        = 16'h2000;
    localparam logic [15:0] EXT_VERSION     = 16'h0100;
    localparam logic [15:0] EXT_MAX_PAYLOAD = 16'h1000;
    localparam logic [7:0]  SEC_TLS         = 8'h00;
    localparam logic [7:0]  SEC_NONE        = 8'h10;
    localparam logic [7:0]  PROTO_TCP       = 8'h00;
    localparam logic [7:0]  BASIC_LEN_BYTE  = 8'h02;
    localparam logic [7:0]  BASIC_RSP_PLEN  = 8'd20;
    localparam logic [7:0]  EXT_RSP_PLEN    = 8'd24;

    // Request lengths and last response byte indexes.
    localparam logic [4:0] BASIC_REQ_LEN  = 5'd10;
    localparam logic [4:0] EXT_REQ_LEN    = 5'd28;
    localparam logic [4:0] BASIC_RSP_LAST = 5'd27;
    localparam logic [4:0] EXT_RSP_LAST   = 5'd31;
    localparam logic [4:0] POS_MAX        = 5'd31;

    // Returns byte idx of the response frame, byte 0 first on the wire.
    function automatic logic [7:0] rsp_byte(
        input logic [4:0]  idx,
        input logic        ext,
        input logic [63:0] addr_high,
        input logic [63:0] addr_low,
        input logic [15:0] port,
        input logic [7:0]  sec
    );
        logic [255:0] frame;
        if (ext)
        begin
            frame = {VER_BYTE, INV_VER_BYTE, EXT_TYPE, 24'h000000, EXT_RSP_PLEN,
                     EXT_VERSION, EXT_MAX_PAYLOAD, addr_high, addr_low, port, sec,
                     PROTO_TCP};
        end
        else
        begin
            frame = {VER_BYTE, INV_VER_BYTE, BASIC_RSP_TYPE, 24'h000000, BASIC_RSP_PLEN,
                     addr_high, addr_low, port, sec, PROTO_TCP, 32'h00000000};
        end
        // Byte idx sits at bit offset 8 * (31 - idx).
        return frame[{~idx, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/drr_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// Configuration register bank of the discovery request responder.
// Depends on drr_pkg for the register indexes and the configuration struct.

module drr_cfg_regs
    import drr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [63:0] wr_data,
    output drr_cfg_t         cfg
);

    drr_cfg_t cfg_reg;
    drr_cfg_t cfg_next;

    // Decode the register index; unknown indexes leave the bank untouched.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_TLS_ADDR_HIGH: cfg_next.tls_addr_high     = wr_data;
                REG_TLS_ADDR_LOW:  cfg_next.tls_addr_low      = wr_data;
                REG_TCP_ADDR_HIGH: cfg_next.tcp_addr_high     = wr_data;
                REG_TCP_ADDR_LOW:  cfg_next.tcp_addr_low      = wr_data;
                REG_TLS_PORT:      cfg_next.tls_port          = wr_data[15:0];
                REG_TCP_PORT:      cfg_next.tcp_port          = wr_data[15:0];
                REG_ENDPOINTS:     cfg_next.endpoints_present = wr_data[1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> hw/rtl/drr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Request checker: tracks the byte position and header checks of one datagram.
// Depends on drr_pkg for constants and the job struct handed to the streamer.

module drr_checker
    import drr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  drr_in_t         in_data,
    input  wire logic [1:0] endpoints_present,
    output drr_job_t        job,
    output logic            at_start
);

    logic [4:0] byte_position_reg, byte_position_next;
    logic       header_fault_reg, header_fault_next;
    logic       version_fault_reg, version_fault_next;
    logic [7:0] security_seen_reg, security_seen_next;
    logic [7:0] protocol_seen_reg, protocol_seen_next;
    logic       port_latched_reg, port_latched_next;

    logic       ext;
    logic [4:0] req_len;
    logic [4:0] pos_inc;
    logic [7:0] b;
    logic [2:0] outcome;
    logic       use_tls;

    assign b       = in_data.rx_byte;
    // The port seen on the first byte holds for the whole datagram.
    assign ext     = (byte_position_reg == '0) ? in_data.extended_port : port_latched_reg;
    assign req_len = ext ? EXT_REQ_LEN : BASIC_REQ_LEN;
    assign pos_inc = (byte_position_reg == POS_MAX) ? POS_MAX : byte_position_reg + 5'd1;

    // Check the current byte against its place in the request.
    always_comb
    begin
        header_fault_next  = header_fault_reg;
        version_fault_next = version_fault_reg;
        security_seen_next = security_seen_reg;
        protocol_seen_next = protocol_seen_reg;
        if (byte_position_reg < req_len)
        begin
            case (byte_position_reg)
                5'd0: if (b != VER_BYTE) header_fault_next = 1'b1;
                5'd1: if (b != INV_VER_BYTE) header_fault_next = 1'b1;
                5'd2:
                begin
                    if (b != (ext ? EXT_TYPE[15:8] : BASIC_REQ_TYPE[15:8]))
                        header_fault_next = 1'b1;
                end
                5'd3:
                begin
                    if (b != (ext ? EXT_TYPE[7:0] : BASIC_REQ_TYPE[7:0]))
                        header_fault_next = 1'b1;
                end
                5'd4, 5'd5, 5'd6: if (!ext && b != 8'h00) header_fault_next = 1'b1;
                5'd7: if (!ext && b != BASIC_LEN_BYTE) header_fault_next = 1'b1;
                5'd8:
                begin
                    if (ext)
                    begin
                        if (b != EXT_VERSION[15:8]) version_fault_next = 1'b1;
                    end
                    else
                    begin
                        security_seen_next = b;
                    end
                end
                5'd9:
                begin
                    if (ext)
                    begin
                        if (b != EXT_VERSION[7:0]) version_fault_next = 1'b1;
                    end
                    else
                    begin
                        protocol_seen_next = b;
                    end
                end
                5'd12: if (ext) security_seen_next = b;
                5'd13: if (ext) protocol_seen_next = b;
                default: ;
            endcase
        end
    end

    // Verdict for the datagram, in order of precedence, with endpoint fallback.
    always_comb
    begin
        outcome = OUT_RESPONSE;
        use_tls = 1'b0;
        priority if (pos_inc < req_len)
            outcome = OUT_TOO_SHORT;
        else if (header_fault_next)
            outcome = OUT_BAD_HEADER;
        else if (ext && version_fault_next)
            outcome = OUT_BAD_VERSION;
        else if (protocol_seen_next != PROTO_TCP)
            outcome = OUT_NO_ENDPOINT;
        else if (security_seen_next == SEC_TLS)
        begin
            priority if (endpoints_present[0])
                use_tls = 1'b1;
            else if (endpoints_present[1])
                use_tls = 1'b0;
            else
                outcome = OUT_NO_ENDPOINT;
        end
        else if (security_seen_next == SEC_NONE)
        begin
            priority if (endpoints_present[1])
                use_tls = 1'b0;
            else if (endpoints_present[0])
                use_tls = 1'b1;
            else
                outcome = OUT_NO_ENDPOINT;
        end
        else
            outcome = OUT_NO_ENDPOINT;
    end

    // Per-datagram state advances on each accepted byte and clears after the final byte.
    always_comb
    begin
        byte_position_next = byte_position_reg;
        port_latched_next  = port_latched_reg;
        if (accept)
        begin
            if (in_data.final_byte)
            begin
                byte_position_next = '0;
                port_latched_next  = 1'b0;
            end
            else
            begin
                byte_position_next = pos_inc;
                port_latched_next  = ext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            header_fault_reg  <= 1'b0;
            version_fault_reg <= 1'b0;
            security_seen_reg <= '0;
            protocol_seen_reg <= '0;
            port_latched_reg  <= 1'b0;
        end
        else
        begin
            byte_position_reg <= byte_position_next;
            port_latched_reg  <= port_latched_next;
            if (accept)
            begin
                if (in_data.final_byte)
                begin
                    header_fault_reg  <= 1'b0;
                    version_fault_reg <= 1'b0;
                    security_seen_reg <= '0;
                    protocol_seen_reg <= '0;
                end
                else
                begin
                    header_fault_reg  <= header_fault_next;
                    version_fault_reg <= version_fault_next;
                    security_seen_reg <= security_seen_next;
                    protocol_seen_reg <= protocol_seen_next;
                end
            end
        end
    end

    assign job.valid   = accept && in_data.final_byte;
    assign job.outcome = outcome;
    assign job.ext     = ext;
    assign job.use_tls = use_tls;
    assign at_start    = (byte_position_reg == '0);

endmodule

`default_nettype wire

>>> hw/rtl/drr_streamer.sv
`timescale 1ns / 1ps
`default_nettype none
// Response streamer: plays out a response frame or a single status item.
// Depends on drr_pkg for the job, configuration and output types and the frame builder.

module drr_streamer
    import drr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  drr_job_t  job,
    input  drr_cfg_t  cfg,
    input  wire logic out_ready,
    output logic      out_valid,
    output drr_out_t  out_data,
    output logic      busy
);

    logic       active_reg, active_next;
    logic [4:0] idx_reg, idx_next;
    logic [4:0] last_idx_reg;
    logic [2:0] outcome_reg;
    logic       ext_reg;
    logic       use_tls_reg;
    logic       out_valid_reg, out_valid_next;
    drr_out_t   out_data_reg;
    drr_out_t   item;
    logic       advance;
    logic       is_last;

    // Move one item into the output register whenever it is free or being taken.
    assign advance = active_reg && (!out_valid_reg || out_ready);
    assign is_last = (idx_reg == last_idx_reg);

    // Build the next result item.
    always_comb
    begin
        item.outcome = outcome_reg;
        item.run_end = is_last;
        if (outcome_reg == OUT_RESPONSE)
        begin
            item.tx_byte = rsp_byte(idx_reg, ext_reg,
                use_tls_reg ? cfg.tls_addr_high : cfg.tcp_addr_high,
                use_tls_reg ? cfg.tls_addr_low : cfg.tcp_addr_low,
                use_tls_reg ? cfg.tls_port : cfg.tcp_port,
                use_tls_reg ? SEC_TLS : SEC_NONE);
        end
        else
        begin
            item.tx_byte = 8'h00;
        end
    end

    // Sequencing of the frame and the output register handshake.
    always_comb
    begin
        active_next    = active_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + 5'd1;
            if (is_last)
                active_next = 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        // A new job only arrives while the streamer is idle.
        if (job.valid)
        begin
            active_next = 1'b1;
            idx_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Job fields and output payload need no reset.
    always_ff @(posedge clk)
    begin
        if (job.valid)
        begin
            outcome_reg <= job.outcome;
            ext_reg     <= job.ext;
            use_tls_reg <= job.use_tls;
            if (job.outcome != OUT_RESPONSE)
                last_idx_reg <= '0;
            else
                last_idx_reg <= job.ext ? EXT_RSP_LAST : BASIC_RSP_LAST;
        end
        if (advance)
            out_data_reg <= item;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign busy      = active_reg;

endmodule

`default_nettype wire

>>> hw/rtl/discovery_request_responder.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the discovery request responder.
// Depends on drr_pkg, drr_cfg_regs, drr_checker and drr_streamer.

// Datagram bytes are taken one per cycle and checked as they stream in; only
// a final byte can be held back, as below. The final byte of a datagram
// produces a 28-byte (basic) or 32-byte (extended) response, or one status
// item, played out one item per cycle from an output register while
// out_ready does not stall it. The response streamer holds one frame at a
// time: while it is still playing out a frame, non-final bytes of the next
// datagram are still taken, but a final byte waits until the streamer is
// free. Configuration writes are always accepted and are to be made while
// no datagram is in flight.

module discovery_request_responder
    import drr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  drr_in_t          in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output drr_out_t         out_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    drr_cfg_t cfg;
    drr_job_t job;
    logic     busy;
    logic     at_start;
    logic     in_accept;

    // A final byte needs the streamer free; other bytes are always taken.
    assign in_ready  = !(in_data.final_byte && busy);
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    drr_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    drr_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (in_accept),
        .in_data           (in_data),
        .endpoints_present (cfg.endpoints_present),
        .job               (job),
        .at_start          (at_start)
    );

    drr_streamer u_streamer (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .cfg       (cfg),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .busy      (busy)
    );

`ifndef SYNTH
    // A request's final byte always starts the streamer.
    a_final_starts_stream: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && in_data.final_byte |=> busy)
        else $error("final byte did not start the response streamer");

    // After a final byte the next datagram starts at position zero.
    a_final_clears_position: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && in_data.final_byte |=> at_start)
        else $error("byte position not cleared after final byte");

    // A status item is a lone zero byte that closes its run.
    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.outcome != OUT_RESPONSE)
            |-> out_data.run_end && (out_data.tx_byte == 8'h00))
        else $error("status item malformed");
`endif

endmodule

`default_nettype wire
